// File: src/dnm_pkg.sv
package dnm_pkg;

  localparam int unsigned OperandW = 16;
  localparam int unsigned ProdW    = 2 * OperandW;
  localparam int unsigned AccW     = 48;
  localparam int unsigned FracBits = 8;
  localparam int unsigned ResultW  = 32;
  localparam int unsigned RoundW   = AccW - FracBits;

  localparam logic [ResultW-1:0] ReluMax  = ResultW'(32767);
  localparam logic [ResultW-1:0] LogitMax = {1'b0, {(ResultW-1){1'b1}}};
  localparam logic [ResultW-1:0] LogitMin = {1'b1, {(ResultW-1){1'b0}}};
  localparam logic               ReluEnableReset = 1'b1;

  typedef logic signed [OperandW-1:0] operand_t;
  typedef logic signed [AccW-1:0]     acc_t;

  // product stage payload handed to the accumulator
  typedef struct packed {
    logic signed [ProdW-1:0] prod;
    operand_t                bias;
    logic                    first;
    logic                    last;
  } prod_t;

endpackage

// File: src/dnm_if.sv
interface dnm_in_if;
  logic                valid;
  logic                ready;
  dnm_pkg::operand_t   activation;
  dnm_pkg::operand_t   weight;
  dnm_pkg::operand_t   bias;
  logic                first;
  logic                last;

  modport source (output valid, activation, weight, bias, first, last, input ready);
  modport sink   (input valid, activation, weight, bias, first, last, output ready);
endinterface

interface dnm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dnm_pkg::ResultW-1:0] neuron_value;

  modport source (output valid, neuron_value, input ready);
  modport sink   (input valid, neuron_value, output ready);
endinterface

// File: src/dnm_mul_stage.sv
module dnm_mul_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  dnm_in_if.sink         in_i,
  output logic           valid_o,
  input  logic           ready_i,
  output dnm_pkg::prod_t prod_o
);

  dnm_pkg::operand_t act_q, wgt_q, bias_q;
  logic              first_q, last_q, va_q;
  dnm_pkg::prod_t    prod_q, prod_d;
  logic              vb_q;
  logic              en_a, en_b;

  assign en_b       = !vb_q || ready_i;
  assign en_a       = !va_q || en_b;
  assign in_i.ready = en_a;

  always_comb begin
    prod_d.prod  = act_q * wgt_q;
    prod_d.bias  = bias_q;
    prod_d.first = first_q;
    prod_d.last  = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (en_a) va_q <= in_i.valid;
      if (en_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && in_i.valid) begin
      act_q   <= in_i.activation;
      wgt_q   <= in_i.weight;
      bias_q  <= in_i.bias;
      first_q <= in_i.first;
      last_q  <= in_i.last;
    end
    if (en_b && va_q) prod_q <= prod_d;
  end

  assign valid_o = vb_q;
  assign prod_o  = prod_q;

endmodule

// File: src/dnm_acc_stage.sv
module dnm_acc_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  dnm_pkg::prod_t prod_i,
  output logic           valid_o,
  input  logic           ready_i,
  output dnm_pkg::acc_t  acc_o
);

  dnm_pkg::acc_t acc_q, acc_d, base;
  logic          emit_q, en;

  assign en      = !emit_q || ready_i;
  assign ready_o = en;

  always_comb begin
    // first item reloads with bias in q32.16
    base  = prod_i.first
          ? {{(dnm_pkg::AccW - dnm_pkg::OperandW - dnm_pkg::FracBits){prod_i.bias[dnm_pkg::OperandW-1]}},
             prod_i.bias, {dnm_pkg::FracBits{1'b0}}}
          : acc_q;
    acc_d = base + {{(dnm_pkg::AccW - dnm_pkg::ProdW){prod_i.prod[dnm_pkg::ProdW-1]}}, prod_i.prod};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      emit_q <= 1'b0;
    end else if (en) begin
      emit_q <= valid_i && prod_i.last;
      if (valid_i) acc_q <= acc_d;
    end
  end

  assign valid_o = emit_q;
  assign acc_o   = acc_q;

endmodule

// File: src/dnm_round_stage.sv
module dnm_round_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          relu_en_i,
  input  logic          valid_i,
  output logic          ready_o,
  input  dnm_pkg::acc_t acc_i,
  dnm_out_if.source     out_o
);

  logic [dnm_pkg::AccW-1:0]    mag_q, mag_d, rnd;
  logic                        neg_q, vd_q, ve_q;
  logic [dnm_pkg::RoundW-1:0]  r;
  logic [dnm_pkg::ResultW-1:0] res_d, res_q;
  logic                        en_d, en_e;

  assign en_e    = !ve_q || out_o.ready;
  assign en_d    = !vd_q || en_e;
  assign ready_o = en_d;

  // magnitude of the q32.16 sum
  assign mag_d = acc_i[dnm_pkg::AccW-1] ? (~acc_i + 1'b1) : acc_i;

  always_comb begin
    rnd = mag_q + dnm_pkg::AccW'(1 << (dnm_pkg::FracBits - 1));
    r   = rnd[dnm_pkg::AccW-1:dnm_pkg::FracBits];
    if (relu_en_i) begin
      if (neg_q) res_d = '0;
      else if (r > dnm_pkg::RoundW'(dnm_pkg::ReluMax)) res_d = dnm_pkg::ReluMax;
      else res_d = r[dnm_pkg::ResultW-1:0];
    end else if (!neg_q) begin
      if (r > dnm_pkg::RoundW'(dnm_pkg::LogitMax)) res_d = dnm_pkg::LogitMax;
      else res_d = r[dnm_pkg::ResultW-1:0];
    end else begin
      if (r > dnm_pkg::RoundW'(dnm_pkg::LogitMin)) res_d = dnm_pkg::LogitMin;
      else res_d = ~r[dnm_pkg::ResultW-1:0] + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (en_d) vd_q <= valid_i;
      if (en_e) ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d && valid_i) begin
      mag_q <= mag_d;
      neg_q <= acc_i[dnm_pkg::AccW-1];
    end
    if (en_e && vd_q) res_q <= res_d;
  end

  assign out_o.valid        = ve_q;
  assign out_o.neuron_value = res_q;

endmodule

// File: src/dense_neuron_mac_q8_8.sv
// dense-layer neuron engine in signed q8.8: stream activation/weight pairs, mark the
// first pair of a neuron (bias loaded) and the last pair (result produced). one pair
// is taken every cycle, back to back, across neuron boundaries, unless the pipeline
// is full behind a stalled result; after the edge that takes its last pair, a result
// moves through the register stages after the input register (product, accumulator,
// magnitude, rounded output). every stage has its own valid bit and stalls only when
// the stage after it is full, so a waiting result does not block new pairs until the
// pipeline has filled. relu_enable is written through cfg_we_i/cfg_wdata_i and must
// only change while nothing is in flight.
module dense_neuron_mac_q8_8 (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  dnm_in_if.sink    in_i,
  dnm_out_if.source out_o
);

  // mode register, relu on after reset
  logic relu_en_q;

  // product stage to accumulator
  logic           prod_valid, prod_ready;
  dnm_pkg::prod_t prod;

  // accumulator to rounding, only last items travel on
  logic          acc_valid, acc_ready;
  dnm_pkg::acc_t acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relu_en_q <= dnm_pkg::ReluEnableReset;
    end else if (cfg_we_i) begin
      relu_en_q <= cfg_wdata_i;
    end
  end

  // input register and 16x16 signed multiply
  dnm_mul_stage u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (prod_valid),
    .ready_i (prod_ready),
    .prod_o  (prod)
  );

  // 48-bit q32.16 running sum, reloaded on a first item
  dnm_acc_stage u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .ready_o (prod_ready),
    .prod_i  (prod),
    .valid_o (acc_valid),
    .ready_i (acc_ready),
    .acc_o   (acc)
  );

  // round half away from zero, then relu clamp or 32-bit saturation
  dnm_round_stage u_round (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .relu_en_i (relu_en_q),
    .valid_i   (acc_valid),
    .ready_o   (acc_ready),
    .acc_i     (acc),
    .out_o     (out_o)
  );

endmodule

// File: src/dnm_checker.sv
module dnm_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_we_i,
  input logic                                cfg_wdata_i,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                in_last_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [dnm_pkg::ResultW-1:0] out_value_i
);

  localparam int unsigned Depth = 5;

  logic       relu_q;
  logic [3:0] pend_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i && in_last_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relu_q <= dnm_pkg::ReluEnableReset;
      pend_q <= '0;
    end else begin
      if (cfg_we_i) relu_q <= cfg_wdata_i;
      pend_q <= pend_q + 4'(in_xfer) - 4'(out_xfer);
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i))
    else $error("result changed while stalled");

  // no result without an accepted last item
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 4'd0)
    else $error("result with no pending neuron");

  // never more neurons in flight than pipeline stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 4'(Depth))
    else $error("too many neurons in flight");

  // when the output side drains, input is never blocked
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input stalled with free output");

  // relu mode results stay in 0..32767
  a_relu_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && relu_q |-> out_value_i[dnm_pkg::ResultW-1:15] == '0)
    else $error("relu result out of range");

endmodule

bind dense_neuron_mac_q8_8 dnm_checker u_dnm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.neuron_value)
);

// File: tb/neuron_sb_pkg.sv
package neuron_sb_pkg;

  import dnm_pkg::*;

  class neuron_scoreboard;
    logic signed [AccW-1:0] acc_q16_16;
    logic                   relu_en;
    logic [ResultW-1:0]     expected_values[$];
    int unsigned            mismatch_count;

    function new();
      acc_q16_16     = '0;
      relu_en        = ReluEnableReset;
      mismatch_count = 0;
    endfunction

    function void set_relu(logic en);
      relu_en = en;
    endfunction

    function int unsigned pending();
      return expected_values.size();
    endfunction

    task report(string msg);
      mismatch_count++;
      if (mismatch_count <= 40) $display("mismatch: %s", msg);
    endtask

    // shift q32.16 to q24.8, round half away from zero, then clamp
    function logic [ResultW-1:0] round_neuron_value();
      logic               neg;
      logic [AccW-1:0]    mag;
      logic [AccW:0]      biased;
      logic [RoundW:0]    rounded;
      neg     = acc_q16_16[AccW-1];
      mag     = neg ? (~acc_q16_16 + 1'b1) : acc_q16_16;
      biased  = {1'b0, mag} + (AccW+1)'(1 << (FracBits - 1));
      rounded = biased[AccW:FracBits];
      if (relu_en) begin
        if (neg || rounded == 0) return '0;
        return (rounded > ReluMax) ? ReluMax : rounded[ResultW-1:0];
      end
      if (!neg) return (rounded > LogitMax) ? LogitMax : rounded[ResultW-1:0];
      if (rounded > LogitMin) return LogitMin;
      return -rounded[ResultW-1:0];
    endfunction

    function void note_pair(operand_t act, operand_t wgt, operand_t bias,
                            logic first, logic last);
      logic signed [ProdW-1:0] prod;
      prod = act * wgt;
      if (first) begin
        acc_q16_16 = {{(AccW-OperandW-FracBits){bias[OperandW-1]}}, bias,
                      {FracBits{1'b0}}};
      end
      acc_q16_16 = acc_q16_16 + {{(AccW-ProdW){prod[ProdW-1]}}, prod};
      if (last) expected_values.push_back(round_neuron_value());
    endfunction

    task check_value(logic [ResultW-1:0] got);
      logic [ResultW-1:0] want;
      if (expected_values.size() == 0) begin
        report($sformatf("neuron_value %0d with no neuron pending", $signed(got)));
        return;
      end
      want = expected_values.pop_front();
      if (got !== want) begin
        report($sformatf("neuron_value got %0d (%h) want %0d (%h)",
                         $signed(got), got, $signed(want), want));
      end
    endtask
  endclass

endpackage

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dnm_pkg::*;
  import neuron_sb_pkg::*;

  // cycles with no transfer on either side before the run is declared hung
  localparam int unsigned StuckLimit = 4000;
  // long receiver hold-off, enough to fill every pipeline stage
  localparam int unsigned HoldCycles = 80;
  // settle time after the last expected result (five register stages)
  localparam int unsigned SettleCycles = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic cfg_wdata;

  dnm_in_if  in_bus ();
  dnm_out_if out_bus ();

  dense_neuron_mac_q8_8 dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  neuron_scoreboard sb = new();

  // sender pacing state
  int unsigned burst_left = 0;
  bit          pacing_on  = 1'b1;
  int unsigned pairs_sent = 0;
  // asks the receiver process for one long stall
  bit          hold_request = 1'b0;
  int unsigned stuck_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // present one pair and hold it until the transfer edge
  task automatic send_pair(operand_t act, operand_t wgt, operand_t bias,
                           logic first, logic last);
    in_bus.valid      <= 1'b1;
    in_bus.activation <= act;
    in_bus.weight     <= wgt;
    in_bus.bias       <= bias;
    in_bus.first      <= first;
    in_bus.last       <= last;
    do @(posedge clk); while (!in_bus.ready);
    // pre-edge sampling: this edge carried the transfer
    sb.note_pair(act, wgt, bias, first, last);
    pairs_sent++;
  endtask

  // called with n >= 1 only, so valid is never lowered and raised in one step
  task automatic pause_sender(int unsigned n);
    in_bus.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // bursts of random length, split by random gaps (sometimes none) if pacing_on
  task automatic send_paced(operand_t act, operand_t wgt, operand_t bias,
                            logic first, logic last);
    int unsigned gap;
    if (pacing_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) pause_sender(gap);
    end
    if (burst_left != 0) burst_left--;
    send_pair(act, wgt, bias, first, last);
  endtask

  // wait until every neuron sent so far has been checked, then let the
  // pipeline settle, since pairs without last leave nothing to wait for
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // only called with nothing in flight
  task automatic write_relu(logic en);
    cfg_we    <= 1'b1;
    cfg_wdata <= en;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_relu(en);
  endtask

  // mix of extremes, small values near zero and full-range values
  function automatic operand_t pick_operand();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          3: return 16'shffff;
          default: return 16'sh0001;
        endcase
      end
      1, 2: return operand_t'($signed($urandom_range(0, 1023)) - 512);
      default: return operand_t'($urandom());
    endcase
  endfunction

  // one neuron: mostly well formed, occasionally with stray first/last marks
  task automatic random_neuron();
    int unsigned len;
    bit          use_first;
    logic        first;
    logic        last;
    len       = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    use_first = ($urandom_range(0, 9) != 0);
    for (int unsigned i = 0; i < len; i++) begin
      first = use_first && (i == 0);
      last  = (i == len - 1);
      if ($urandom_range(0, 19) == 0) begin
        first = 1'($urandom_range(0, 1));
        last  = 1'($urandom_range(0, 1));
      end
      send_paced(pick_operand(), pick_operand(), pick_operand(), first, last);
    end
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned start;
    start = pairs_sent;
    while (pairs_sent - start < n) random_neuron();
  endtask

  // long neuron of one repeated product, emitting every 'every' terms without
  // a new first, so the logit climbs past signed 32 bits and must saturate
  task automatic ramp(operand_t act, operand_t wgt, int unsigned terms,
                      int unsigned every);
    for (int unsigned i = 0; i < terms; i++) begin
      send_paced(act, wgt, pick_operand(), i == 0, (i + 1) % every == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: stall pattern changes every stretch, with one long hold
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned mode;
    int unsigned stretch;
    out_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(20, 100);
      repeat (stretch) begin
        @(posedge clk);
        if (hold_request) begin
          out_bus.ready <= 1'b0;
          repeat (HoldCycles) @(posedge clk);
          hold_request = 1'b0;
        end else begin
          case (mode)
            0: out_bus.ready <= 1'b1;
            1: out_bus.ready <= 1'($urandom_range(0, 1));
            2: out_bus.ready <= ($urandom_range(0, 3) == 0);
            default: out_bus.ready <= ($urandom_range(0, 9) != 0);
          endcase
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) sb.check_value(out_bus.neuron_value);
  end

  // watchdog: counts cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles == StuckLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_bus.valid      <= 1'b0;
    in_bus.activation <= '0;
    in_bus.weight     <= '0;
    in_bus.bias       <= '0;
    in_bus.first      <= 1'b0;
    in_bus.last       <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // relu mode from reset
    // no first right after reset: the sum starts from zero
    send_paced(16'sh0100, 16'sh0100, 16'sh7fff, 1'b0, 1'b1);
    // no first after an emitted neuron: the sum carries on, bias ignored
    send_paced(16'sh0100, 16'sh0100, 16'sh8000, 1'b0, 1'b1);
    // one-term neurons: clamp at the top, negative and zero give 0
    send_paced(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1, 1'b1);
    send_paced(16'sh8000, 16'sh7fff, 16'sh8000, 1'b1, 1'b1);
    send_paced(16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 1'b1);
    // exact half rounds up, just below half rounds to 0
    send_paced(16'sh0001, 16'sh0080, 16'sh0000, 1'b1, 1'b1);
    send_paced(16'sh0001, 16'sh007f, 16'sh0000, 1'b1, 1'b1);
    // three-term neuron, bias on the middle term must be ignored
    send_paced(16'sh8000, 16'sh8000, 16'sh0000, 1'b1, 1'b0);
    send_paced(16'shffff, 16'shffff, 16'shffff, 1'b0, 1'b0);
    send_paced(16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 1'b1);
    // alternating bit patterns
    send_paced(16'sh5555, 16'shaaaa, 16'sh5555, 1'b1, 1'b1);
    send_paced(16'shaaaa, 16'sh5555, 16'shaaaa, 1'b1, 1'b1);
    drain();

    // logit mode
    write_relu(1'b0);
    // negative half rounds away from zero, below half gives 0
    send_paced(16'shffff, 16'sh0080, 16'sh0000, 1'b1, 1'b1);
    send_paced(16'shffff, 16'sh007f, 16'sh0000, 1'b1, 1'b1);
    send_paced(16'sh8000, 16'sh7fff, 16'sh8000, 1'b1, 1'b1);
    send_paced(16'sh8000, 16'sh8000, 16'sh7fff, 1'b1, 1'b1);
    // bias alone, most negative
    send_paced(16'sh0000, 16'sh0000, 16'sh8000, 1'b1, 1'b0);
    send_paced(16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 1'b1);
    drain();

    write_relu(1'b1);
    random_phase(40);
    drain();

    // receiver holds off while the sender streams back to back, so the
    // pipeline fills and input ready must drop
    write_relu(1'b0);
    hold_request = 1'b1;
    pacing_on    = 1'b0;
    random_phase(30);
    pacing_on    = 1'b1;
    random_phase(20);
    drain();

    // logit saturation on the positive side, results just below and past the top
    ramp(16'sh8000, 16'sh8000, 520, 52);
    drain();

    random_phase(30);
    drain();

    if (sb.mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
